### rtl/ird_pkg.sv
// ----------------------------------------------------------------------------
// ird_pkg
// shared widths, register codes, reset values and stage-to-stage types for
// the ir reflection detector
// ----------------------------------------------------------------------------
package ird_pkg;

    localparam int TIME_W     = 32;
    localparam int ADC_W      = 10;
    localparam int THRESH_W   = 10;
    localparam int PERIOD_W   = 16;
    localparam int SETTLE_W   = 8;
    localparam int AVG_W      = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RST = 10'd0;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 8'd2;

    // control from the window stage to the averaging stage
    typedef struct packed {
        logic emitter_on;
        logic avg_upd;
    } win_ctrl_t;

    // one result word
    typedef struct packed {
        logic             emitter_on;
        logic             is_detected;
        logic             detect_changed;
        logic [AVG_W-1:0] average_level;
    } result_t;

endpackage

### rtl/ir_reflect_detector.sv
// ----------------------------------------------------------------------------
// ir_reflect_detector
// modulated ir proximity detector with a moving-average window of reflected
// differences
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  in       | in_valid/in_stall | now_ms, adc_sample
//  out      | out_valid/out_stall | emitter_on, is_detected, detect_changed,
//           |                   | average_level
//  cfg      | cfg_we            | cfg_index, cfg_wdata
//
//  one word per cycle sustained while out_stall stays low; a word taken
//  passes the input register, window stage and averaging stage into the
//  output register
//  each stage moves on when it is empty or the one after it moves, so the
//  pipe keeps filling while out_stall holds a finished result
//  reset clears the phase timer, window fill count, sum and flags; window
//  memory contents need no clearing
// ----------------------------------------------------------------------------
module ir_reflect_detector
    import ird_pkg::*;
#(
    parameter int WINDOW_LEN  = 8,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [ADC_W-1:0]      adc_sample,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  emitter_on,
    output logic                  is_detected,
    output logic                  detect_changed,
    output logic [AVG_W-1:0]      average_level,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SumW = SAMPLE_BITS + $clog2(WINDOW_LEN);

    logic [THRESH_W-1:0] thresh_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [PERIOD_W-1:0] idle_limit;

    logic                   s0_valid_reg;
    logic [TIME_W-1:0]      s0_now_reg;
    logic [SAMPLE_BITS-1:0] s0_sample_reg;

    logic                   s1_valid_reg;
    win_ctrl_t              s1_ctrl_reg;
    logic [SumW-1:0]        s1_sum_reg;

    logic                   out_valid_reg;
    result_t                out_reg;

    logic                   ready0;
    logic                   ready1;
    logic                   ready2;
    logic                   step_a;
    logic                   step_b;

    win_ctrl_t              win_ctrl;
    logic [SumW-1:0]        win_sum;
    result_t                avg_result;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RST;
            period_reg <= PERIOD_RST;
            settle_reg <= SETTLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_PERIOD:    period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_SETTLE:    settle_reg <= cfg_wdata[SETTLE_W-1:0];
                default:       ;
            endcase
        end
    end

    // idle wait saturates at zero when settle is not shorter than period
    assign idle_limit = (period_reg > PERIOD_W'(settle_reg)) ?
                        (period_reg - PERIOD_W'(settle_reg)) : '0;

    // flow control
    assign ready2   = !out_valid_reg || !out_stall;
    assign ready1   = !s1_valid_reg || ready2;
    assign ready0   = !s0_valid_reg || ready1;
    assign step_a   = s0_valid_reg && ready1;
    assign step_b   = s1_valid_reg && ready2;
    assign in_stall = !ready0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                s0_valid_reg <= in_valid;
            end
            if (ready1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (ready2)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready0)
        begin
            s0_now_reg    <= now_ms;
            s0_sample_reg <= SAMPLE_BITS'(adc_sample);
        end
        if (step_a)
        begin
            s1_ctrl_reg <= win_ctrl;
            s1_sum_reg  <= win_sum;
        end
        if (step_b)
        begin
            out_reg <= avg_result;
        end
    end

    ird_window #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step_a),
        .now_ms     (s0_now_reg),
        .sample     (s0_sample_reg),
        .idle_limit (idle_limit),
        .settle_ms  (settle_reg),
        .ctrl       (win_ctrl),
        .sum        (win_sum)
    );

    ird_average #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_average (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step_b),
        .ctrl      (s1_ctrl_reg),
        .sum       (s1_sum_reg),
        .threshold (thresh_reg),
        .result    (avg_result)
    );

    assign out_valid      = out_valid_reg;
    assign emitter_on     = out_reg.emitter_on;
    assign is_detected    = out_reg.is_detected;
    assign detect_changed = out_reg.detect_changed;
    assign average_level  = out_reg.average_level;

endmodule

### rtl/ird_window.sv
// ----------------------------------------------------------------------------
// ird_window
// emitter phase sequencing and the ring window of reflected differences with
// its running sum
// ----------------------------------------------------------------------------
module ird_window
    import ird_pkg::*;
#(
    parameter int WINDOW_LEN  = 8,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      step,
    input  logic [TIME_W-1:0]                         now_ms,
    input  logic [SAMPLE_BITS-1:0]                    sample,
    input  logic [PERIOD_W-1:0]                       idle_limit,
    input  logic [SETTLE_W-1:0]                       settle_ms,
    output win_ctrl_t                                 ctrl,
    output logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] sum
);

    localparam int SumW  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int IdxW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FillW = $clog2(WINDOW_LEN + 1);
    localparam logic [IdxW-1:0]  LastPos = IdxW'(WINDOW_LEN - 1);
    localparam logic [FillW-1:0] FullCnt = FillW'(WINDOW_LEN);

    logic                   emitting_reg,  emitting_next;
    logic [TIME_W-1:0]      stamp_reg,     stamp_next;
    logic [SAMPLE_BITS-1:0] ambient_reg,   ambient_next;
    logic [IdxW-1:0]        pos_reg,       pos_next;
    logic [FillW-1:0]       fill_reg,      fill_next;
    logic [SumW-1:0]        sum_reg,       sum_next;
    logic [SAMPLE_BITS-1:0] rd_reg;

    logic [SAMPLE_BITS-1:0] mem [WINDOW_LEN];

    logic [TIME_W-1:0]      elapsed;
    logic                   start_emit;
    logic                   stop_emit;
    logic                   wr_en;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] old_entry;
    logic [IdxW-1:0]        pos_inc;
    logic [IdxW-1:0]        rd_addr;
    logic [FillW-1:0]       fill_inc;

    always_comb
    begin
        elapsed    = now_ms - stamp_reg;
        start_emit = !emitting_reg && (elapsed > TIME_W'(idle_limit));
        stop_emit  = emitting_reg && (elapsed > TIME_W'(settle_ms));
        wr_en      = step && stop_emit;

        diff = (ambient_reg > sample) ? (ambient_reg - sample) : (sample - ambient_reg);
        // an entry not yet written since reset reads as zero; while filling,
        // the write position always points at such an entry
        old_entry = (fill_reg == FullCnt) ? rd_reg : '0;
        pos_inc   = (pos_reg == LastPos) ? '0 : pos_reg + IdxW'(1);
        fill_inc  = (fill_reg == FullCnt) ? fill_reg : fill_reg + FillW'(1);

        emitting_next = emitting_reg;
        stamp_next    = stamp_reg;
        ambient_next  = ambient_reg;
        pos_next      = pos_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        priority if (start_emit)
        begin
            emitting_next = 1'b1;
            stamp_next    = now_ms;
            ambient_next  = sample;
        end
        else if (stop_emit)
        begin
            emitting_next = 1'b0;
            stamp_next    = now_ms;
            pos_next      = pos_inc;
            fill_next     = fill_inc;
            sum_next      = sum_reg - SumW'(old_entry) + SumW'(diff);
        end

        rd_addr = wr_en ? pos_inc : pos_reg;

        ctrl.emitter_on = emitting_next;
        ctrl.avg_upd    = stop_emit && (fill_inc == FullCnt);
        sum             = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitting_reg <= 1'b0;
            stamp_reg    <= '0;
            ambient_reg  <= '0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
        end
        else if (step)
        begin
            emitting_reg <= emitting_next;
            stamp_reg    <= stamp_next;
            ambient_reg  <= ambient_next;
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
        end
    end

    // window memory, read data always holds the entry at the next write spot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= diff;
        end
        if (wr_en && (rd_addr == pos_reg))
        begin
            rd_reg <= diff;
        end
        else
        begin
            rd_reg <= mem[rd_addr];
        end
    end

endmodule

### rtl/ird_average.sv
// ----------------------------------------------------------------------------
// ird_average
// window average by reciprocal multiply, threshold compare and detection flag
// ----------------------------------------------------------------------------
module ird_average
    import ird_pkg::*;
#(
    parameter int WINDOW_LEN  = 8,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      step,
    input  win_ctrl_t                                 ctrl,
    input  logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] sum,
    input  logic [THRESH_W-1:0]                       threshold,
    output result_t                                   result
);

    localparam int SumW   = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int ShiftW = SumW + $clog2(WINDOW_LEN);
    localparam int RecipW = SumW + 1;
    localparam int ProdW  = SumW + RecipW;
    localparam int CmpW   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
    // rounded-up reciprocal, exact floor division for every sum below 2^SumW
    localparam logic [63:0] RecipWide =
        ((64'd1 << ShiftW) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RecipW-1:0] Recip = RecipW'(RecipWide);

    logic             flag_reg, flag_next;
    logic [AVG_W-1:0] avg_reg,  avg_next;

    logic [ProdW-1:0]       prod;
    logic [SAMPLE_BITS-1:0] avg;

    always_comb
    begin
        prod = ProdW'(sum) * ProdW'(Recip);
        avg  = prod[ShiftW +: SAMPLE_BITS];

        flag_next = flag_reg;
        avg_next  = avg_reg;
        if (ctrl.avg_upd)
        begin
            flag_next = CmpW'(avg) >= CmpW'(threshold);
            avg_next  = AVG_W'(avg);
        end

        result.emitter_on     = ctrl.emitter_on;
        result.is_detected    = flag_next;
        result.detect_changed = flag_next != flag_reg;
        result.average_level  = avg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            avg_reg  <= '0;
        end
        else if (step)
        begin
            flag_reg <= flag_next;
            avg_reg  <= avg_next;
        end
    end

endmodule
